// File: hdl/fba_pkg.sv
// Shared types and constants for the fit block allocator.
// Field widths, register indexes, strategy and function codes.
// No dependencies.
package fba_pkg;

    // Fixed field widths of the channels and the configuration port
    localparam int IN_IDX_W   = 4;
    localparam int IN_SIZE_W  = 16;
    localparam int OUT_BLK_W  = 5;
    localparam int OUT_SIZE_W = 16;
    localparam int MODE_W     = 2;
    localparam int BLOCKS_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Function codes of an input item
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Allocation strategies; the fourth code chooses nothing
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd1;

    // Register reset values
    localparam logic [MODE_W-1:0]   FIT_MODE_RESET = FIT_FIRST;
    localparam logic [BLOCKS_W-1:0] BLOCKS_RESET   = 5'd16;

    // Verdict of the compare unit on one block
    typedef struct packed {
        logic take;       // block becomes the current choice
        logic first_hit;  // first fit found its block, end the scan
    } t_pick;

endpackage

// File: hdl/fba_in_if.sv
// Input channel of the fit block allocator: valid/ready plus item fields.
// Depends on fba_pkg for field widths.
interface fba_in_if;
    logic                           valid;
    logic                           ready;
    logic                           func;
    logic [fba_pkg::IN_IDX_W-1:0]   block_index;
    logic [fba_pkg::IN_SIZE_W-1:0]  size;

    modport source (output valid, func, block_index, size, input ready);
    modport sink   (input valid, func, block_index, size, output ready);
endinterface

// File: hdl/fba_out_if.sv
// Result channel of the fit block allocator: valid/ready plus result fields.
// Depends on fba_pkg for field widths.
interface fba_out_if;
    logic                            valid;
    logic                            ready;
    logic [fba_pkg::OUT_BLK_W-1:0]   allocated_block;
    logic [fba_pkg::OUT_SIZE_W-1:0]  remaining_size;

    modport source (output valid, allocated_block, remaining_size, input ready);
    modport sink   (input valid, allocated_block, remaining_size, output ready);
endinterface

// File: hdl/fba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module fba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register one read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fba_pick.sv
// Shared compare unit: judges one block's free size against the request
// under the active strategy. Depends on fba_pkg for codes and t_pick.
module fba_pick #(
    parameter int SIZE_BITS = 16
) (
    input  logic [fba_pkg::MODE_W-1:0] i_mode,
    input  logic                       i_found,
    input  logic [SIZE_BITS-1:0]       i_held,
    input  logic [SIZE_BITS-1:0]       i_cur,
    input  logic [SIZE_BITS-1:0]       i_want,
    output fba_pkg::t_pick             o_pick
);
    import fba_pkg::*;

    logic fits;

    assign fits = (i_want <= i_cur);

    // Keep the lower index on ties: replace only on a strict improvement
    always_comb begin
        o_pick = '0;
        case (i_mode)
            FIT_FIRST: begin
                o_pick.take      = fits;
                o_pick.first_hit = fits;
            end
            FIT_BEST: begin
                o_pick.take = fits && (!i_found || (i_cur < i_held));
            end
            FIT_WORST: begin
                o_pick.take = fits && (i_cur > i_held);
            end
            default: begin
                o_pick = '0;
            end
        endcase
    end

endmodule

// File: hdl/fit_block_allocator.sv
// Fit block allocator: a load is written to the table while idle, and the
// block stays ready for the next item. A request scans the blocks in use;
// first fit stops early at its hit. One comparator walks the free-size RAM
// through its single read port, one block per cycle.
// Synchronous active-low reset clears control and the valid bits; an
// unwritten block reads as zero, so no clearing pass follows reset.
module fit_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fba_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fba_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    fba_in_if.sink                           i_req,
    fba_out_if.source                        o_rsp
);
    import fba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int LIM_W = (CNT_W > BLOCKS_W) ? CNT_W : BLOCKS_W;
    localparam int EXT_W = (SIZE_BITS > IN_SIZE_W) ? SIZE_BITS : IN_SIZE_W;
    localparam logic [LIM_W-1:0] NUM_BLOCKS_L = LIM_W'(NUM_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [MODE_W-1:0]      r_fit_mode;
    logic [BLOCKS_W-1:0]    r_blocks_in_use;
    logic [NUM_BLOCKS-1:0]  r_valid;
    logic                   r_rd_vld;
    logic [LIM_W-1:0]       r_limit, n_limit;
    logic [LIM_W-1:0]       r_issue, n_issue;
    logic                   r_cmp_on, n_cmp_on;
    logic [IDX_W-1:0]       r_cmp_idx, n_cmp_idx;
    logic                   r_found, n_found;
    logic [IDX_W-1:0]       r_chosen, n_chosen;
    logic [SIZE_BITS-1:0]   r_held, n_held;
    logic [SIZE_BITS-1:0]   r_want, n_want;
    logic                   r_out_valid;
    logic [OUT_BLK_W-1:0]   r_out_block;
    logic [OUT_SIZE_W-1:0]  r_out_size;

    logic                   req_xfer;
    logic                   rsp_xfer;
    logic                   mode_known;
    logic [LIM_W-1:0]       blocks_ext;
    logic [LIM_W-1:0]       limit;
    logic [LIM_W-1:0]       load_idx_ext;
    logic                   load_in_range;
    logic [EXT_W-1:0]       size_ext;
    logic [SIZE_BITS-1:0]   want;
    logic                   issuing;
    logic [IDX_W-1:0]       rd_addr;
    logic [SIZE_BITS-1:0]   rd_data;
    logic [SIZE_BITS-1:0]   cur;
    t_pick                  pick;
    logic                   last_cmp;
    logic                   commit;
    logic [SIZE_BITS-1:0]   left;
    logic [EXT_W-1:0]       left_ext;
    logic [LIM_W-1:0]       block_num;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [SIZE_BITS-1:0]   ram_wdata;

    assign req_xfer = i_req.valid && i_req.ready;
    assign rsp_xfer = o_rsp.valid && o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // Clamp the search count to the table depth
    assign blocks_ext = LIM_W'(r_blocks_in_use);
    assign limit      = (blocks_ext > NUM_BLOCKS_L) ? NUM_BLOCKS_L : blocks_ext;
    assign mode_known = r_fit_mode inside {FIT_FIRST, FIT_BEST, FIT_WORST};

    // Fit the 16-bit size field to the table width
    assign size_ext      = EXT_W'(i_req.size);
    assign want          = size_ext[SIZE_BITS-1:0];
    assign load_idx_ext  = LIM_W'(i_req.block_index);
    assign load_in_range = (load_idx_ext < NUM_BLOCKS_L);

    // Scan read side: issue one block address per cycle
    assign issuing = (r_state == S_SCAN) && (r_issue < r_limit);
    assign rd_addr = r_issue[IDX_W-1:0];
    assign cur     = r_rd_vld ? rd_data : '0;
    assign last_cmp = ((LIM_W'(r_cmp_idx) + LIM_W'(1)) == r_limit);

    // Commit side: write back and load the result register
    assign commit    = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign left      = r_held - r_want;
    assign left_ext  = EXT_W'(left);
    assign block_num = LIM_W'(r_chosen) + LIM_W'(1);

    fba_pick #(
        .SIZE_BITS (SIZE_BITS)
    ) u_pick (
        .i_mode  (r_fit_mode),
        .i_found (r_found),
        .i_held  (r_held),
        .i_cur   (cur),
        .i_want  (r_want),
        .o_pick  (pick)
    );

    // Table write: a load while idle, or the write-back of a chosen block
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = load_idx_ext[IDX_W-1:0];
        ram_wdata = want;
        if (req_xfer && (i_req.func == FUNC_LOAD) && load_in_range) begin
            ram_we = 1'b1;
        end else if (commit && r_found) begin
            ram_we    = 1'b1;
            ram_waddr = r_chosen;
            ram_wdata = left;
        end
    end

    fba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Sequencer: accept, scan with the shared compare unit, commit
    always_comb begin
        n_state   = r_state;
        n_limit   = r_limit;
        n_issue   = r_issue;
        n_cmp_on  = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_found   = r_found;
        n_chosen  = r_chosen;
        n_held    = r_held;
        n_want    = r_want;
        case (r_state)
            S_IDLE: begin
                if (req_xfer && (i_req.func == FUNC_REQUEST)) begin
                    n_want  = want;
                    n_limit = limit;
                    n_issue = '0;
                    n_found = 1'b0;
                    n_held  = '0;
                    n_state = (mode_known && (limit != '0)) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (issuing) begin
                    n_issue   = r_issue + LIM_W'(1);
                    n_cmp_on  = 1'b1;
                    n_cmp_idx = rd_addr;
                end
                if (r_cmp_on) begin
                    if (pick.take) begin
                        n_found  = 1'b1;
                        n_chosen = r_cmp_idx;
                        n_held   = cur;
                    end
                    if (pick.first_hit || last_cmp) begin
                        n_cmp_on = 1'b0;
                        n_state  = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmp_on <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cmp_on <= n_cmp_on;
            r_found  <= n_found;
        end
    end

    // Working registers of the scan
    always_ff @(posedge i_clk) begin
        r_limit   <= n_limit;
        r_issue   <= n_issue;
        r_cmp_idx <= n_cmp_idx;
        r_chosen  <= n_chosen;
        r_held    <= n_held;
        r_want    <= n_want;
        r_rd_vld  <= r_valid[rd_addr];
    end

    // Mark blocks written since reset; unwritten blocks read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[ram_waddr] <= 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode      <= FIT_MODE_RESET;
            r_blocks_in_use <= BLOCKS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIT_MODE:      r_fit_mode      <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCKS_IN_USE: r_blocks_in_use <= i_cfg_data[BLOCKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Result register: hold until the transfer, reload on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (rsp_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_block <= r_found ? block_num[OUT_BLK_W-1:0] : '0;
            r_out_size  <= r_found ? left_ext[OUT_SIZE_W-1:0] : '0;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.allocated_block = r_out_block;
    assign o_rsp.remaining_size  = r_out_size;

    // A new result appears only out of the commit state
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside commit");

    // An accepted request never lets the block return to idle at once
    a_request_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_xfer && (i_req.func == FUNC_REQUEST)) |=> (r_state != S_IDLE))
        else $error("request dropped without a result");

    // Compared block stays inside the searched range
    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_on |-> (LIM_W'(r_cmp_idx) < r_limit))
        else $error("compare index beyond search limit");

    // A chosen block lies inside the searched range
    a_choice_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_found) |-> (LIM_W'(r_chosen) < r_limit))
        else $error("chosen block beyond search limit");

    // Worst fit never chooses an empty block
    a_worst_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_found && (r_fit_mode == FIT_WORST))
            |-> (r_held != '0))
        else $error("worst fit chose an empty block");

endmodule

// File: test/fit_block_allocator_tb.sv
// Self-checking testbench for fit_block_allocator: loads and requests under all
// strategies and a range of block counts, with random idling on both channels.
// Depends on fba_pkg, fba_in_if, fba_out_if and the fit_block_allocator RTL.
`timescale 1ns / 100ps

module fit_block_allocator_tb;
    import fba_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;
    localparam int PHASES = 11;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 25;

    typedef struct packed {
        logic [OUT_BLK_W-1:0]  blk;
        logic [OUT_SIZE_W-1:0] rem;
    } t_alloc_result;

    // Tracks the free-size table and the queue of predicted allocations
    class alloc_scoreboard;
        logic [IN_SIZE_W-1:0] free_size [TABLE_DEPTH];
        logic [MODE_W-1:0]    fit_mode;
        logic [BLOCKS_W-1:0]  blocks_in_use;
        t_alloc_result        grant_q[$];
        int errors;
        int loads;
        int requests;
        int grants;
        int refusals;
        int results;

        function new();
            foreach (free_size[j]) free_size[j] = '0;
            fit_mode      = FIT_MODE_RESET;
            blocks_in_use = BLOCKS_RESET;
            errors   = 0;
            loads    = 0;
            requests = 0;
            grants   = 0;
            refusals = 0;
            results  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_FIT_MODE)
                fit_mode = data[MODE_W-1:0];
            else if (idx == CFG_BLOCKS_IN_USE)
                blocks_in_use = data[BLOCKS_W-1:0];
        endfunction

        // Pick a block for a request, -1 when nothing qualifies
        function int choose_block(logic [IN_SIZE_W-1:0] want);
            int limit;
            int chosen;
            logic [IN_SIZE_W-1:0] held;
            limit  = (blocks_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_in_use);
            chosen = -1;
            held   = '0;
            for (int j = 0; j < limit; j++) begin
                if (want > free_size[IN_IDX_W'(j)])
                    continue;
                case (fit_mode)
                    FIT_FIRST: return j;
                    FIT_BEST: begin
                        if (chosen < 0 || free_size[IN_IDX_W'(j)] < held) begin
                            chosen = j;
                            held   = free_size[IN_IDX_W'(j)];
                        end
                    end
                    FIT_WORST: begin
                        // a zero-size block never wins here
                        if (free_size[IN_IDX_W'(j)] > held) begin
                            chosen = j;
                            held   = free_size[IN_IDX_W'(j)];
                        end
                    end
                    default: return -1;
                endcase
            end
            return chosen;
        endfunction

        // Apply one accepted input transfer to the table
        function void note_item(logic func, logic [IN_IDX_W-1:0] idx,
                                logic [IN_SIZE_W-1:0] size);
            int c;
            t_alloc_result r;
            if (func == FUNC_LOAD) begin
                free_size[idx] = size;
                loads++;
            end else begin
                requests++;
                c = choose_block(size);
                if (c < 0) begin
                    r = '0;
                    refusals++;
                end else begin
                    free_size[IN_IDX_W'(c)] = free_size[IN_IDX_W'(c)] - size;
                    r.blk = OUT_BLK_W'(c + 1);
                    r.rem = free_size[IN_IDX_W'(c)];
                    grants++;
                end
                grant_q.push_back(r);
            end
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(logic [OUT_BLK_W-1:0] blk, logic [OUT_SIZE_W-1:0] rem);
            t_alloc_result r;
            results++;
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected result blk=%0d rem=%0d", $time, blk, rem);
                errors++;
                return;
            end
            r = grant_q.pop_front();
            if (blk !== r.blk) begin
                $display("%0t: allocated_block expected %0d actual %0d",
                         $time, r.blk, blk);
                errors++;
            end
            if (rem !== r.rem) begin
                $display("%0t: remaining_size expected %0d actual %0d",
                         $time, r.rem, rem);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fba_in_if  req_ch ();
    fba_out_if rsp_ch ();

    alloc_scoreboard sb = new();

    // Knobs shared by the sender, the receiver and the phase sequencer
    int   gap_max;
    int   rx_style;
    logic hold_req;
    int   holds_done;

    fit_block_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.allocated_block, rsp_ch.remaining_size);
    end

    // Receiver: rotate a random stall mask, hold off for a long stretch on request
    initial begin : rx_proc
        int k;
        int cyc;
        logic [7:0] pat;
        cyc = 0;
        pat = 8'hFF;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                rsp_ch.ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge i_clk);
                hold_req = 1'b0;
                holds_done++;
            end else begin
                if (cyc % 32 == 0) begin
                    pat = (rx_style == 0) ? 8'hFF : 8'($urandom);
                    if (pat == 8'h00)
                        pat = 8'h01;
                end
                rsp_ch.ready <= pat[cyc[2:0]];
                cyc++;
            end
        end
    end

    // Offer one item and hold it until the transfer happens
    task automatic send_item(logic func, logic [IN_IDX_W-1:0] idx,
                             logic [IN_SIZE_W-1:0] size);
        req_ch.valid       <= 1'b1;
        req_ch.func        <= func;
        req_ch.block_index <= idx;
        req_ch.size        <= size;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_item(func, idx, size);
    endtask

    task automatic pause_input(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Let every pending request finish, then give the block time to settle
    task automatic wait_idle();
        pause_input(1);
        while (sb.grant_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Mostly small sizes so requests keep fitting, with full-range outliers
    function automatic logic [IN_SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return IN_SIZE_W'($urandom_range(0, 15));
        else if (r < 60)
            return IN_SIZE_W'($urandom_range(0, 255));
        else if (r < 80)
            return IN_SIZE_W'($urandom_range(0, 4095));
        else if (r < 95)
            return IN_SIZE_W'($urandom);
        else
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endfunction

    // Random loads and requests in bursts with random gaps
    task automatic run_random(int n);
        int left;
        int burst;
        int gap;
        logic func;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                func = ($urandom_range(0, 99) < 35) ? FUNC_LOAD : FUNC_REQUEST;
                send_item(func, IN_IDX_W'($urandom), pick_size());
                burst--;
                left--;
            end
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0)
                pause_input(gap);
        end
    endtask

    // Hand-picked items: empty table, ties, zero-size requests, every mode, counts 0, 1, 16, 31
    task automatic run_directed();
        send_item(FUNC_REQUEST, 4'd0, 16'd0);
        send_item(FUNC_REQUEST, 4'd0, 16'd1);
        send_item(FUNC_LOAD, 4'd0, 16'hFFFF);
        send_item(FUNC_LOAD, 4'd15, 16'd100);
        send_item(FUNC_LOAD, 4'd3, 16'd40);
        send_item(FUNC_LOAD, 4'd9, 16'd40);
        send_item(FUNC_REQUEST, 4'd0, 16'd40);
        send_item(FUNC_REQUEST, 4'd15, 16'hFFFF);
        wait_idle();
        set_config(CFG_FIT_MODE, CFG_DATA_W'(FIT_BEST));
        send_item(FUNC_REQUEST, 4'd0, 16'd40);
        send_item(FUNC_REQUEST, 4'd0, 16'd30);
        send_item(FUNC_REQUEST, 4'd0, 16'd0);
        wait_idle();
        set_config(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
        send_item(FUNC_REQUEST, 4'd0, 16'd0);
        send_item(FUNC_REQUEST, 4'd0, 16'd100);
        wait_idle();
        set_config(CFG_FIT_MODE, CFG_DATA_W'(FIT_UNUSED));
        send_item(FUNC_REQUEST, 4'd0, 16'd1);
        wait_idle();
        set_config(CFG_FIT_MODE, CFG_DATA_W'(FIT_FIRST));
        set_config(CFG_BLOCKS_IN_USE, 5'd0);
        send_item(FUNC_REQUEST, 4'd0, 16'd0);
        wait_idle();
        set_config(CFG_BLOCKS_IN_USE, 5'd31);
        send_item(FUNC_REQUEST, 4'd0, 16'd100);
        send_item(FUNC_LOAD, 4'd15, 16'hFFFF);
        send_item(FUNC_REQUEST, 4'd0, 16'hFFFF);
        wait_idle();
        set_config(CFG_FIT_MODE, CFG_DATA_W'(FIT_WORST));
        set_config(CFG_BLOCKS_IN_USE, 5'd1);
        send_item(FUNC_REQUEST, 4'd0, 16'd50);
        send_item(FUNC_LOAD, 4'd0, 16'd0);
        send_item(FUNC_REQUEST, 4'd0, 16'd0);
        wait_idle();
    endtask

    initial begin : stimulus
        logic [MODE_W-1:0]   mode_tab [8];
        logic [BLOCKS_W-1:0] count_tab [8];
        logic [MODE_W-1:0]   mode;
        logic [BLOCKS_W-1:0] count;
        mode_tab  = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FIRST,
                      FIT_BEST, FIT_WORST, FIT_UNUSED, FIT_BEST};
        count_tab = '{5'd16, 5'd16, 5'd16, 5'd1, 5'd31, 5'd8, 5'd16, 5'd0};
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = '0;
        i_cfg_data         = '0;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_LOAD;
        req_ch.block_index = '0;
        req_ch.size        = '0;
        gap_max            = 4;
        rx_style           = 1;
        hold_req           = 1'b0;
        holds_done         = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Random phases, each under its own strategy and block count
        for (int p = 0; p < PHASES; p++) begin
            mode  = (p < 8) ? mode_tab[p[2:0]] : MODE_W'($urandom);
            count = (p < 8) ? count_tab[p[2:0]] : BLOCKS_W'($urandom_range(1, 31));
            set_config(CFG_FIT_MODE, CFG_DATA_W'(mode));
            set_config(CFG_BLOCKS_IN_USE, CFG_DATA_W'(count));
            gap_max  = (p % 3 == 0) ? 0 : $urandom_range(3, 8);
            rx_style = (p % 4 == 1) ? 0 : 1;
            if (p == 2)
                hold_req = 1'b1;
            run_random(PHASE_ITEMS);
            wait_idle();
        end

        // Drain and watch for stray results
        while (sb.grant_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d loads and %0d requests (%0d granted, %0d refused)",
                 sb.loads, sb.requests, sb.grants, sb.refusals);
        $display("over %0d random phases, %0d long receiver hold-offs, %0d results checked",
                 PHASES, holds_done, sb.results);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
